// ===== rtl/rsdq_pkg.sv =====
// Shared types and constants for the rod surface damping block.
// Used by the top level and the testbench; no dependencies.
package rsdq_pkg;

    typedef logic signed [31:0] q_t;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NODE_COUNT    = 5;

    // quadrature nodes and weights in thousandths
    localparam int NODE_MILLI [NODE_COUNT] = '{-906, -538, 0, 538, 906};
    localparam int WT_MILLI   [NODE_COUNT] = '{237, 479, 569, 479, 237};

    localparam longint PI_MICRO = 3141593;

    // |nz| threshold of 1e-4 is tested as |nz| * NZ_SCALE > one
    localparam longint NZ_SCALE = 10000;

    // quotient bits below the saturation point; also the square root depth
    localparam int DIV_STEPS = 31;

    typedef enum logic [0:0] {
        REG_SURFACE_RADIUS = 1'b0,
        REG_DAMPING_COEFF  = 1'b1
    } cfg_reg_e;

endpackage

// ===== rtl/rsdq_rod_if.sv =====
// Input channel of the rod surface damping block: one rod per transfer.
// Plain valid/ready handshake; no package dependency.
interface rsdq_rod_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] height_z;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] dir_z;
    logic        [30:0] rod_length;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] spin_x;
    logic signed [31:0] spin_y;
    logic signed [31:0] spin_z;

    modport source (
        output valid, height_z, dir_x, dir_y, dir_z, rod_length,
               vel_x, vel_y, spin_x, spin_y, spin_z,
        input  ready
    );
    modport sink (
        input  valid, height_z, dir_x, dir_y, dir_z, rod_length,
               vel_x, vel_y, spin_x, spin_y, spin_z,
        output ready
    );
endinterface

// ===== rtl/rsdq_damp_if.sv =====
// Output channel of the rod surface damping block: force and torque per transfer.
// Plain valid/ready handshake; no package dependency.
interface rsdq_damp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
    logic               in_contact;

    modport source (
        output valid, force_x, force_y, torque_x, torque_y, torque_z, in_contact,
        input  ready
    );
    modport sink (
        input  valid, force_x, force_y, torque_x, torque_y, torque_z, in_contact,
        output ready
    );
endinterface

// ===== rtl/rod_surface_damping_quadrature.sv =====
// Rod surface damping: viscous force and torque of a rod on a curved substrate.
// Depends on rsdq_pkg, rsdq_rod_if and rsdq_damp_if.
//
// Usage:
//   rod  (sink)   : one rod per transfer (height, direction, length, velocities).
//   damp (source) : one result per rod, in order: force x/y, torque x/y/z and
//                   the contact flag. A rod off the surface gives all zeros.
//   cfg_we/cfg_index/cfg_wdata : write surface radius or damping coefficient;
//                   write only while no rod is in flight.
// Throughput is one rod per cycle while the skid register is free. The depth is
// set by the 31-step pipelined dividers (force scale, crossing point) and the
// six pipelined square root lanes running alongside.
// Reset empties the pipeline and sets both registers to 1.0.
// When the receiver stalls, one result is caught in a skid register while the
// pipeline keeps moving; with the skid register full the whole pipeline holds
// and rod.ready drops until the receiver takes a result.
module rod_surface_damping_quadrature #(
    parameter int FRAC_BITS = rsdq_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  rsdq_pkg::cfg_reg_e cfg_index,
    input  logic        [30:0] cfg_wdata,
    rsdq_rod_if.sink           rod,
    rsdq_damp_if.source        damp
);
    import rsdq_pkg::*;

    localparam int NPT      = NODE_COUNT;
    localparam int ST_IN    = 0;
    localparam int ST_A     = 1;
    localparam int ST_B     = 2;
    localparam int ST_C     = 3;
    localparam int ST_E     = 4;
    localparam int ST_T1    = ST_E + DIV_STEPS + 1;
    localparam int LAST     = ST_T1 + 8;
    localparam int NSTAGE   = LAST + 1;

    localparam longint ONE_L = longint'(1) <<< FRAC_BITS;
    localparam q_t     ONE_Q = q_t'(ONE_L);
    localparam logic signed [63:0] HALF_LSB = 64'sd1 <<< (FRAC_BITS - 1);

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] d;
        logic [30:0] nlo;
        logic [30:0] q;
        logic        neg;
        logic        zero;
        logic        ovf;
    } div_t;

    typedef struct packed {
        logic [61:0] arg;
        logic [32:0] rem;
        logic [30:0] root;
    } sqr_t;

    typedef struct {
        q_t   z;
        q_t   len;
        q_t   half;
        q_t   n [3];
        q_t   v [2];
        q_t   w [3];
        q_t   t;
        q_t   s2;
        q_t   mln;
        q_t   num2;
        logic nzbig;
        q_t   r [NPT];
        logic contact;
        q_t   c2;
        q_t   e1;
        q_t   p [NPT][3];
        q_t   delta [NPT];
        q_t   e;
        q_t   xa [NPT][2];
        q_t   xb [NPT][2];
        q_t   vrel [NPT][2];
        q_t   kf;
        q_t   rr0;
        q_t   a [NPT];
        q_t   dens [NPT];
        q_t   p0 [3];
        q_t   g [NPT];
        q_t   xea [2];
        q_t   xeb [2];
        q_t   f [NPT][2];
        q_t   vrele [2];
        q_t   wf [NPT][2];
        q_t   tp [NPT][4];
        q_t   fe [2];
        q_t   m [NPT][3];
        q_t   te [4];
        q_t   wm [NPT][3];
        q_t   xe [3];
        q_t   psf [2];
        q_t   psm [3];
        q_t   res [5];
    } work_t;

    function automatic q_t sat(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return Q_MAX;
        else if (x < -64'sd2147483648)
            return Q_MIN;
        return q_t'(x);
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        return sat(64'(a) + 64'(b));
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        return sat(64'(a) - 64'(b));
    endfunction

    function automatic q_t qneg(input q_t a);
        return sat(-64'(a));
    endfunction

    // round half up: arithmetic shift of the biased product
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [63:0] pr;
        pr = 64'(a) * 64'(b) + HALF_LSB;
        return sat(pr >>> FRAC_BITS);
    endfunction

    function automatic longint milli_q(input int mv);
        longint mag;
        mag = (mv < 0) ? -longint'(mv) : longint'(mv);
        mag = (mag * ONE_L + 500) / 1000;
        return (mv < 0) ? -mag : mag;
    endfunction

    // magnitudes, overflow test and first partial remainder
    function automatic div_t div_entry(input q_t a, input q_t b);
        div_t        r;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] nn;
        ma     = a[31] ? (~a + 32'd1) : a;
        mb     = b[31] ? (~b + 32'd1) : b;
        nn     = 64'(ma) << FRAC_BITS;
        r.ovf  = nn >= (64'(mb) << DIV_STEPS);
        r.rem  = 32'(nn >> DIV_STEPS);
        r.nlo  = nn[30:0];
        r.d    = mb;
        r.q    = '0;
        r.neg  = a[31] ^ b[31];
        r.zero = (a == '0);
        return r;
    endfunction

    function automatic div_t div_step(input div_t s);
        div_t        r;
        logic [32:0] tr;
        r  = s;
        tr = {s.rem, s.nlo[30]};
        if (tr >= {1'b0, s.d})
        begin
            r.rem = 32'(tr - {1'b0, s.d});
            r.q   = {s.q[29:0], 1'b1};
        end
        else
        begin
            r.rem = tr[31:0];
            r.q   = {s.q[29:0], 1'b0};
        end
        r.nlo = {s.nlo[29:0], 1'b0};
        return r;
    endfunction

    function automatic q_t div_final(input div_t s);
        q_t qv;
        qv = q_t'({1'b0, s.q});
        if (s.zero)
            return '0;
        else if (s.ovf)
            return s.neg ? Q_MIN : Q_MAX;
        return s.neg ? -qv : qv;
    endfunction

    function automatic sqr_t sqr_entry(input q_t x);
        sqr_t r;
        r.arg  = (x > 0) ? (62'(x) << FRAC_BITS) : '0;
        r.rem  = '0;
        r.root = '0;
        return r;
    endfunction

    function automatic sqr_t sqr_step(input sqr_t s);
        sqr_t        r;
        logic [34:0] t4;
        logic [34:0] trial;
        t4    = {s.rem, s.arg[61:60]};
        trial = {2'b00, s.root, 2'b01};
        if (t4 >= trial)
        begin
            r.rem  = 33'(t4 - trial);
            r.root = {s.root[29:0], 1'b1};
        end
        else
        begin
            r.rem  = t4[32:0];
            r.root = {s.root[29:0], 1'b0};
        end
        r.arg = {s.arg[59:0], 2'b00};
        return r;
    endfunction

    localparam q_t NODE_Q [NPT] = '{
        q_t'(milli_q(NODE_MILLI[0])), q_t'(milli_q(NODE_MILLI[1])),
        q_t'(milli_q(NODE_MILLI[2])), q_t'(milli_q(NODE_MILLI[3])),
        q_t'(milli_q(NODE_MILLI[4]))};
    localparam q_t WT_Q [NPT] = '{
        q_t'(milli_q(WT_MILLI[0])), q_t'(milli_q(WT_MILLI[1])),
        q_t'(milli_q(WT_MILLI[2])), q_t'(milli_q(WT_MILLI[3])),
        q_t'(milli_q(WT_MILLI[4]))};
    localparam q_t PI_Q = q_t'((PI_MICRO * ONE_L + 500000) / 1000000);

    logic [30:0] radius_reg;
    logic [30:0] damping_reg;
    q_t          radius_q;
    q_t          damping_q;

    work_t pipe_reg  [NSTAGE];
    work_t pipe_next [NSTAGE];
    logic  vld_reg   [NSTAGE];
    div_t  dv_reg    [DIV_STEPS + 1][2];
    div_t  dv_next   [DIV_STEPS + 1][2];
    sqr_t  sq_reg    [DIV_STEPS + 1][NPT + 1];
    sqr_t  sq_next   [DIV_STEPS + 1][NPT + 1];

    q_t    skid_res_reg [5];
    logic  skid_ct_reg;
    logic  skid_vld_reg;
    logic  en;
    q_t    out_res [5];
    logic  out_ct;

    assign radius_q  = q_t'(radius_reg);
    assign damping_q = q_t'(damping_reg);

    // pipeline moves whenever the skid register is free
    assign en        = !skid_vld_reg;
    assign rod.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 31'(ONE_L);
            damping_reg <= 31'(ONE_L);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SURFACE_RADIUS: radius_reg  <= cfg_wdata;
                REG_DAMPING_COEFF:  damping_reg <= cfg_wdata;
                default:            radius_reg  <= radius_reg;
            endcase
        end
    end

    always_comb
    begin
        logic signed [63:0] anz;
        logic signed [63:0] rabs;
        q_t                 rr;
        q_t                 sr;
        int                 s;
        int                 i;
        int                 k;
        int                 l;

        pipe_next[ST_IN] = pipe_reg[ST_IN];
        for (s = 1; s < NSTAGE; s++)
            pipe_next[s] = pipe_reg[s - 1];
        dv_next = dv_reg;
        sq_next = sq_reg;

        // input register
        pipe_next[ST_IN].z    = rod.height_z;
        pipe_next[ST_IN].n[0] = q_t'(rod.dir_x);
        pipe_next[ST_IN].n[1] = q_t'(rod.dir_y);
        pipe_next[ST_IN].n[2] = q_t'(rod.dir_z);
        pipe_next[ST_IN].len  = q_t'(rod.rod_length);
        pipe_next[ST_IN].half = q_t'(rod.rod_length >> 1);
        pipe_next[ST_IN].v[0] = rod.vel_x;
        pipe_next[ST_IN].v[1] = rod.vel_y;
        pipe_next[ST_IN].w[0] = rod.spin_x;
        pipe_next[ST_IN].w[1] = rod.spin_y;
        pipe_next[ST_IN].w[2] = rod.spin_z;

        // end offset, nz^2, L*nu, R - z, |nz| test, node positions
        pipe_next[ST_A].t    = qmul(pipe_reg[ST_IN].half, pipe_reg[ST_IN].n[2]);
        pipe_next[ST_A].s2   = qmul(pipe_reg[ST_IN].n[2], pipe_reg[ST_IN].n[2]);
        pipe_next[ST_A].mln  = qmul(pipe_reg[ST_IN].len, damping_q);
        pipe_next[ST_A].num2 = qsub(radius_q, pipe_reg[ST_IN].z);
        anz = 64'(pipe_reg[ST_IN].n[2]);
        if (anz < 0)
            anz = -anz;
        pipe_next[ST_A].nzbig = (anz * NZ_SCALE) > ONE_L;
        for (i = 0; i < NPT; i++)
            pipe_next[ST_A].r[i] = qmul(NODE_Q[i], pipe_reg[ST_IN].half);

        // contact test, cos^2, crossing scale, node offsets
        pipe_next[ST_B].contact =
            (qsub(radius_q, qsub(pipe_reg[ST_A].z, pipe_reg[ST_A].t)) > 0) &&
            (qsub(radius_q, qadd(pipe_reg[ST_A].z, pipe_reg[ST_A].t)) > 0);
        pipe_next[ST_B].c2 = qsub(ONE_Q, pipe_reg[ST_A].s2);
        pipe_next[ST_B].e1 = qmul(pipe_reg[ST_A].mln, PI_Q);
        for (i = 0; i < NPT; i++)
            for (k = 0; k < 3; k++)
                pipe_next[ST_B].p[i][k] = qmul(pipe_reg[ST_A].r[i], pipe_reg[ST_A].n[k]);

        // crossing scale times nz^2, depths and w x p partial products
        pipe_next[ST_C].e = qmul(pipe_reg[ST_B].e1, pipe_reg[ST_B].s2);
        for (i = 0; i < NPT; i++)
        begin
            pipe_next[ST_C].delta[i] =
                qsub(radius_q, qadd(pipe_reg[ST_B].z, pipe_reg[ST_B].p[i][2]));
            pipe_next[ST_C].xa[i][0] = qmul(pipe_reg[ST_B].w[1], pipe_reg[ST_B].p[i][2]);
            pipe_next[ST_C].xb[i][0] = qmul(pipe_reg[ST_B].w[2], pipe_reg[ST_B].p[i][1]);
            pipe_next[ST_C].xa[i][1] = qmul(pipe_reg[ST_B].w[2], pipe_reg[ST_B].p[i][0]);
            pipe_next[ST_C].xb[i][1] = qmul(pipe_reg[ST_B].w[0], pipe_reg[ST_B].p[i][2]);
        end

        // relative velocities; divider and square root entry
        for (i = 0; i < NPT; i++)
            for (k = 0; k < 2; k++)
                pipe_next[ST_E].vrel[i][k] = qadd(pipe_reg[ST_C].v[k],
                    qsub(pipe_reg[ST_C].xa[i][k], pipe_reg[ST_C].xb[i][k]));
        dv_next[0][0] = div_entry(pipe_reg[ST_C].mln, radius_q);
        dv_next[0][1] = div_entry(pipe_reg[ST_C].num2, pipe_reg[ST_C].n[2]);
        for (l = 0; l < NPT; l++)
            sq_next[0][l] = sqr_entry(pipe_reg[ST_C].delta[l]);
        sq_next[0][NPT] = sqr_entry(radius_q);

        // one quotient bit and one root bit per stage
        for (k = 1; k <= DIV_STEPS; k++)
        begin
            dv_next[k][0] = div_step(dv_reg[k - 1][0]);
            dv_next[k][1] = div_step(dv_reg[k - 1][1]);
            for (l = 0; l <= NPT; l++)
                sq_next[k][l] = sqr_step(sq_reg[k - 1][l]);
        end

        // T1: force scale, crossing point, sqrt(R)*sqrt(delta)
        pipe_next[ST_T1].kf = div_final(dv_reg[DIV_STEPS][0]);
        rr = pipe_reg[ST_T1 - 1].nzbig ? div_final(dv_reg[DIV_STEPS][1]) : '0;
        rabs = 64'(rr);
        if (rabs < 0)
            rabs = -rabs;
        if (rabs >= 64'(pipe_reg[ST_T1 - 1].half))
            rr = '0;
        pipe_next[ST_T1].rr0 = rr;
        sr = q_t'(sq_reg[DIV_STEPS][NPT].root);
        for (i = 0; i < NPT; i++)
            pipe_next[ST_T1].a[i] = qmul(sr, q_t'(sq_reg[DIV_STEPS][i].root));

        // T2: contact density, crossing point position
        for (i = 0; i < NPT; i++)
            pipe_next[ST_T1 + 1].dens[i] = (pipe_reg[ST_T1].delta[i] > 0) ?
                qmul(pipe_reg[ST_T1].a[i], pipe_reg[ST_T1].c2) : '0;
        for (k = 0; k < 3; k++)
            pipe_next[ST_T1 + 1].p0[k] = qmul(pipe_reg[ST_T1].rr0, pipe_reg[ST_T1].n[k]);

        // T3: gains and w x p0 partial products
        for (i = 0; i < NPT; i++)
            pipe_next[ST_T1 + 2].g[i] =
                qmul(pipe_reg[ST_T1 + 1].kf, pipe_reg[ST_T1 + 1].dens[i]);
        pipe_next[ST_T1 + 2].xea[0] =
            qmul(pipe_reg[ST_T1 + 1].w[1], pipe_reg[ST_T1 + 1].p0[2]);
        pipe_next[ST_T1 + 2].xeb[0] =
            qmul(pipe_reg[ST_T1 + 1].w[2], pipe_reg[ST_T1 + 1].p0[1]);
        pipe_next[ST_T1 + 2].xea[1] =
            qmul(pipe_reg[ST_T1 + 1].w[2], pipe_reg[ST_T1 + 1].p0[0]);
        pipe_next[ST_T1 + 2].xeb[1] =
            qmul(pipe_reg[ST_T1 + 1].w[0], pipe_reg[ST_T1 + 1].p0[2]);

        // T4: node forces, crossing relative velocity
        for (i = 0; i < NPT; i++)
            for (k = 0; k < 2; k++)
                pipe_next[ST_T1 + 3].f[i][k] =
                    qneg(qmul(pipe_reg[ST_T1 + 2].g[i], pipe_reg[ST_T1 + 2].vrel[i][k]));
        for (k = 0; k < 2; k++)
            pipe_next[ST_T1 + 3].vrele[k] = qadd(pipe_reg[ST_T1 + 2].v[k],
                qsub(pipe_reg[ST_T1 + 2].xea[k], pipe_reg[ST_T1 + 2].xeb[k]));

        // T5: weighted forces, p x f products, crossing force
        for (i = 0; i < NPT; i++)
        begin
            for (k = 0; k < 2; k++)
                pipe_next[ST_T1 + 4].wf[i][k] = qmul(pipe_reg[ST_T1 + 3].f[i][k], WT_Q[i]);
            pipe_next[ST_T1 + 4].tp[i][0] =
                qmul(pipe_reg[ST_T1 + 3].p[i][2], pipe_reg[ST_T1 + 3].f[i][1]);
            pipe_next[ST_T1 + 4].tp[i][1] =
                qmul(pipe_reg[ST_T1 + 3].p[i][2], pipe_reg[ST_T1 + 3].f[i][0]);
            pipe_next[ST_T1 + 4].tp[i][2] =
                qmul(pipe_reg[ST_T1 + 3].p[i][0], pipe_reg[ST_T1 + 3].f[i][1]);
            pipe_next[ST_T1 + 4].tp[i][3] =
                qmul(pipe_reg[ST_T1 + 3].p[i][1], pipe_reg[ST_T1 + 3].f[i][0]);
        end
        for (k = 0; k < 2; k++)
            pipe_next[ST_T1 + 4].fe[k] =
                qneg(qmul(pipe_reg[ST_T1 + 3].e, pipe_reg[ST_T1 + 3].vrele[k]));

        // T6: node torques (fz is zero), p0 x fe products
        for (i = 0; i < NPT; i++)
        begin
            pipe_next[ST_T1 + 5].m[i][0] = qneg(pipe_reg[ST_T1 + 4].tp[i][0]);
            pipe_next[ST_T1 + 5].m[i][1] = pipe_reg[ST_T1 + 4].tp[i][1];
            pipe_next[ST_T1 + 5].m[i][2] =
                qsub(pipe_reg[ST_T1 + 4].tp[i][2], pipe_reg[ST_T1 + 4].tp[i][3]);
        end
        pipe_next[ST_T1 + 5].te[0] =
            qmul(pipe_reg[ST_T1 + 4].p0[2], pipe_reg[ST_T1 + 4].fe[1]);
        pipe_next[ST_T1 + 5].te[1] =
            qmul(pipe_reg[ST_T1 + 4].p0[2], pipe_reg[ST_T1 + 4].fe[0]);
        pipe_next[ST_T1 + 5].te[2] =
            qmul(pipe_reg[ST_T1 + 4].p0[0], pipe_reg[ST_T1 + 4].fe[1]);
        pipe_next[ST_T1 + 5].te[3] =
            qmul(pipe_reg[ST_T1 + 4].p0[1], pipe_reg[ST_T1 + 4].fe[0]);

        // T7: weighted torques, crossing torque
        for (i = 0; i < NPT; i++)
            for (k = 0; k < 3; k++)
                pipe_next[ST_T1 + 6].wm[i][k] = qmul(pipe_reg[ST_T1 + 5].m[i][k], WT_Q[i]);
        pipe_next[ST_T1 + 6].xe[0] = qneg(pipe_reg[ST_T1 + 5].te[0]);
        pipe_next[ST_T1 + 6].xe[1] = pipe_reg[ST_T1 + 5].te[1];
        pipe_next[ST_T1 + 6].xe[2] =
            qsub(pipe_reg[ST_T1 + 5].te[2], pipe_reg[ST_T1 + 5].te[3]);

        // T8: first three nodes, summed in node order (saturation is order dependent)
        for (k = 0; k < 2; k++)
            pipe_next[ST_T1 + 7].psf[k] = qadd(qadd(pipe_reg[ST_T1 + 6].wf[0][k],
                pipe_reg[ST_T1 + 6].wf[1][k]), pipe_reg[ST_T1 + 6].wf[2][k]);
        for (k = 0; k < 3; k++)
            pipe_next[ST_T1 + 7].psm[k] = qadd(qadd(pipe_reg[ST_T1 + 6].wm[0][k],
                pipe_reg[ST_T1 + 6].wm[1][k]), pipe_reg[ST_T1 + 6].wm[2][k]);

        // T9: remaining nodes, crossing term, contact mask
        for (k = 0; k < 2; k++)
            pipe_next[LAST].res[k] = pipe_reg[LAST - 1].contact ?
                qadd(qadd(qadd(pipe_reg[LAST - 1].psf[k], pipe_reg[LAST - 1].wf[3][k]),
                    pipe_reg[LAST - 1].wf[4][k]), pipe_reg[LAST - 1].fe[k]) : '0;
        for (k = 0; k < 3; k++)
            pipe_next[LAST].res[2 + k] = pipe_reg[LAST - 1].contact ?
                qadd(qadd(qadd(pipe_reg[LAST - 1].psm[k], pipe_reg[LAST - 1].wm[3][k]),
                    pipe_reg[LAST - 1].wm[4][k]), pipe_reg[LAST - 1].xe[k]) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg <= pipe_next;
            dv_reg   <= dv_next;
            sq_reg   <= sq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NSTAGE; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[ST_IN] <= rod.valid;
            for (int s = 1; s < NSTAGE; s++)
                vld_reg[s] <= vld_reg[s - 1];
        end
    end

    // skid register catches the last stage when the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_vld_reg <= 1'b0;
        else if (skid_vld_reg)
            skid_vld_reg <= !damp.ready;
        else
            skid_vld_reg <= vld_reg[LAST] && !damp.ready;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_vld_reg)
        begin
            skid_res_reg <= pipe_reg[LAST].res;
            skid_ct_reg  <= pipe_reg[LAST].contact;
        end
    end

    always_comb
    begin
        if (skid_vld_reg)
        begin
            out_res = skid_res_reg;
            out_ct  = skid_ct_reg;
        end
        else
        begin
            out_res = pipe_reg[LAST].res;
            out_ct  = pipe_reg[LAST].contact;
        end
    end

    assign damp.valid      = skid_vld_reg || vld_reg[LAST];
    assign damp.force_x    = out_res[0];
    assign damp.force_y    = out_res[1];
    assign damp.torque_x   = out_res[2];
    assign damp.torque_y   = out_res[3];
    assign damp.torque_z   = out_res[4];
    assign damp.in_contact = out_ct;

endmodule

// ===== verif/rod_surface_damping_quadrature_test.sv =====
// Self-checking testbench for rod_surface_damping_quadrature.
// Drives rods through rsdq_rod_if, predicts damping with a fixed-point model of
// its own and checks each rsdq_damp_if transfer; needs rsdq_pkg and both interfaces.
`timescale 1ns / 1ps

module rod_surface_damping_quadrature_test;
    import rsdq_pkg::*;

    localparam longint ONE  = 64'sd65536;
    localparam longint HALF = 64'sd32768;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    typedef longint vec3_t [3];

    typedef struct {
        logic signed [31:0] height_z;
        logic signed [17:0] dir_x, dir_y, dir_z;
        logic        [30:0] rod_length;
        logic signed [31:0] vel_x, vel_y, spin_x, spin_y, spin_z;
    } rod_t;

    typedef struct {
        logic signed [31:0] force_x, force_y, torque_x, torque_y, torque_z;
        logic               in_contact;
    } damp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    cfg_reg_e cfg_index = REG_SURFACE_RADIUS;
    logic [30:0] cfg_wdata = '0;

    rsdq_rod_if  rod_ch ();
    rsdq_damp_if damp_ch ();

    rod_surface_damping_quadrature u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rod       (rod_ch.sink),
        .damp      (damp_ch.source)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rod_t   rods_pending [$];
    damp_t  damp_expected [$];
    longint radius_q = ONE;
    longint damping_q = ONE;
    int     errors = 0;
    bit     calm = 1'b0;
    bit     rod_taken = 1'b0;
    int     src_gap = 0;
    int     sink_gap = 0;

    function automatic longint sat32(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    // round to nearest, halves up: floor of (a*b + half) / one
    function automatic longint fx_mul(longint a, longint b);
        return sat32((a * b + HALF) >>> 16);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        if (b == 0) return a > 0 ? SMAX : (a < 0 ? SMIN : 0);
        return sat32((a * ONE) / b);
    endfunction

    function automatic longint fx_sqrt(longint x);
        longint unsigned v, res, bitv;
        if (x <= 0) return 0;
        v = longint'(x) << 16;
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return sat32(longint'(res));
    endfunction

    function automatic longint cross_k(vec3_t a, vec3_t b, int k);
        if (k == 0) return sat32(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]));
        if (k == 1) return sat32(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]));
        return sat32(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]));
    endfunction

    function automatic longint milli(int k);
        return (longint'(k) * ONE + 500) / 1000;
    endfunction

    function automatic damp_t predict_damping(rod_t r, longint rad, longint nu);
        damp_t  o;
        vec3_t  n, w, p, p0, f, fe;
        longint z, len, half, d1, d2, s2, c2, kf, e, rr0, sr, pi_q, absnz;
        longint rq, delta, dens, g, wt, v0, v1, sf0, sf1;
        longint sm [3];
        z = longint'(r.height_z);
        n[0] = longint'(r.dir_x); n[1] = longint'(r.dir_y); n[2] = longint'(r.dir_z);
        w[0] = longint'(r.spin_x); w[1] = longint'(r.spin_y); w[2] = longint'(r.spin_z);
        v0 = longint'(r.vel_x); v1 = longint'(r.vel_y);
        len = longint'(r.rod_length);
        o = '{default: '0};
        half = len >>> 1;
        d1 = sat32(rad - sat32(z - fx_mul(half, n[2])));
        d2 = sat32(rad - sat32(z + fx_mul(half, n[2])));
        if ((d1 < d2 ? d1 : d2) <= 0) return o;
        pi_q = (longint'(PI_MICRO) * ONE + 500000) / 1000000;
        s2 = fx_mul(n[2], n[2]);
        c2 = sat32(ONE - s2);
        kf = fx_div(fx_mul(len, nu), rad);
        e = fx_mul(fx_mul(fx_mul(len, nu), pi_q), s2);
        sr = fx_sqrt(rad);
        rr0 = 0;
        absnz = n[2] < 0 ? -n[2] : n[2];
        if (absnz * NZ_SCALE > ONE)
        begin
            rr0 = fx_div(sat32(rad - z), n[2]);
            if ((rr0 < 0 ? -rr0 : rr0) >= half) rr0 = 0;
        end
        sf0 = 0; sf1 = 0; sm = '{0, 0, 0};
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            rq = fx_mul(NODE_MILLI[i] < 0 ? -milli(-NODE_MILLI[i]) : milli(NODE_MILLI[i]), half);
            wt = milli(WT_MILLI[i]);
            for (int k = 0; k < 3; k++) p[k] = fx_mul(rq, n[k]);
            delta = sat32(rad - sat32(z + fx_mul(rq, n[2])));
            dens = delta > 0 ? fx_mul(fx_mul(sr, fx_sqrt(delta)), c2) : 0;
            g = fx_mul(kf, dens);
            f[0] = sat32(-fx_mul(g, sat32(v0 + cross_k(w, p, 0))));
            f[1] = sat32(-fx_mul(g, sat32(v1 + cross_k(w, p, 1))));
            f[2] = 0;
            sf0 = sat32(sf0 + fx_mul(f[0], wt));
            sf1 = sat32(sf1 + fx_mul(f[1], wt));
            for (int k = 0; k < 3; k++) sm[k] = sat32(sm[k] + fx_mul(cross_k(p, f, k), wt));
        end
        for (int k = 0; k < 3; k++) p0[k] = fx_mul(rr0, n[k]);
        fe[0] = sat32(-fx_mul(e, sat32(v0 + cross_k(w, p0, 0))));
        fe[1] = sat32(-fx_mul(e, sat32(v1 + cross_k(w, p0, 1))));
        fe[2] = 0;
        o.force_x  = 32'(sat32(sf0 + fe[0]));
        o.force_y  = 32'(sat32(sf1 + fe[1]));
        o.torque_x = 32'(sat32(sm[0] + cross_k(p0, fe, 0)));
        o.torque_y = 32'(sat32(sm[1] + cross_k(p0, fe, 1)));
        o.torque_z = 32'(sat32(sm[2] + cross_k(p0, fe, 2)));
        o.in_contact = 1'b1;
        return o;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // input side: predict on every rod transfer
    always @(posedge clk)
    begin
        rod_taken <= rod_ch.valid && rod_ch.ready;
        if (rst_n && rod_ch.valid && rod_ch.ready)
        begin
            rod_t r;
            r.height_z = rod_ch.height_z; r.dir_x = rod_ch.dir_x;
            r.dir_y = rod_ch.dir_y; r.dir_z = rod_ch.dir_z;
            r.rod_length = rod_ch.rod_length; r.vel_x = rod_ch.vel_x;
            r.vel_y = rod_ch.vel_y; r.spin_x = rod_ch.spin_x;
            r.spin_y = rod_ch.spin_y; r.spin_z = rod_ch.spin_z;
            damp_expected.push_back(predict_damping(r, radius_q, damping_q));
        end
    end

    // output side: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && damp_ch.valid && damp_ch.ready)
        begin
            damp_t x;
            if (damp_expected.size() == 0)
                report_mismatch("unexpected transfer", longint'(damp_ch.force_x), 0);
            else
            begin
                x = damp_expected.pop_front();
                if (damp_ch.force_x !== x.force_x)
                    report_mismatch("force_x", damp_ch.force_x, x.force_x);
                if (damp_ch.force_y !== x.force_y)
                    report_mismatch("force_y", damp_ch.force_y, x.force_y);
                if (damp_ch.torque_x !== x.torque_x)
                    report_mismatch("torque_x", damp_ch.torque_x, x.torque_x);
                if (damp_ch.torque_y !== x.torque_y)
                    report_mismatch("torque_y", damp_ch.torque_y, x.torque_y);
                if (damp_ch.torque_z !== x.torque_z)
                    report_mismatch("torque_z", damp_ch.torque_z, x.torque_z);
                if (damp_ch.in_contact !== x.in_contact)
                    report_mismatch("in_contact", damp_ch.in_contact, x.in_contact);
            end
        end
    end

    // rod driver
    always @(negedge clk)
    begin
        if (rst_n && (!rod_ch.valid || rod_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                rod_ch.valid <= 1'b0;
            end
            else if (rods_pending.size() > 0 && (calm || $urandom_range(0, 5) != 0))
            begin
                rod_t r;
                r = rods_pending.pop_front();
                rod_ch.height_z <= r.height_z; rod_ch.dir_x <= r.dir_x;
                rod_ch.dir_y <= r.dir_y; rod_ch.dir_z <= r.dir_z;
                rod_ch.rod_length <= r.rod_length; rod_ch.vel_x <= r.vel_x;
                rod_ch.vel_y <= r.vel_y; rod_ch.spin_x <= r.spin_x;
                rod_ch.spin_y <= r.spin_y; rod_ch.spin_z <= r.spin_z;
                rod_ch.valid <= 1'b1;
            end
            else
            begin
                if (rods_pending.size() > 0) src_gap = int'($urandom_range(0, 2));
                rod_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver stalls
    always @(negedge clk)
    begin
        if (calm)
            damp_ch.ready <= 1'b1;
        else if (sink_gap > 0)
        begin
            sink_gap--;
            damp_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            sink_gap = int'($urandom_range(0, 2));
            damp_ch.ready <= 1'b0;
        end
        else
            damp_ch.ready <= 1'b1;
    end

    task automatic add_rod(longint z, longint nx, longint ny, longint nz, longint len,
                           longint vx, longint vy, longint wx, longint wy, longint wz);
        rod_t r;
        r.height_z = 32'(z); r.dir_x = 18'(nx); r.dir_y = 18'(ny); r.dir_z = 18'(nz);
        r.rod_length = 31'(len); r.vel_x = 32'(vx); r.vel_y = 32'(vy);
        r.spin_x = 32'(wx); r.spin_y = 32'(wy); r.spin_z = 32'(wz);
        rods_pending.push_back(r);
    endtask

    function automatic longint rnd32();
        return longint'($signed($urandom()));
    endfunction

    function automatic longint rnd_span(longint m);
        return longint'($urandom_range(0, 32'(2 * m))) - m;
    endfunction

    // mostly rods lying near the surface so contact and crossing paths are exercised
    task automatic add_random_rod();
        longint len, z;
        if ($urandom_range(0, 4) == 0)
            add_rod(rnd32(), rnd_span(131071) - longint'($urandom_range(0, 1)),
                    rnd_span(131071), rnd_span(131071),
                    longint'($urandom() & 32'h7FFF_FFFF), rnd32(), rnd32(),
                    rnd32(), rnd32(), rnd32());
        else
        begin
            len = longint'($urandom_range(0, 8 * 65536));
            z = sat32(radius_q + rnd_span(len));
            add_rod(z, rnd_span(65536), rnd_span(65536), rnd_span(65536), len,
                    rnd_span(4 * 65536), rnd_span(4 * 65536), rnd_span(2 * 65536),
                    rnd_span(2 * 65536), rnd_span(2 * 65536));
        end
    endtask

    task automatic settle();
        do @(posedge clk);
        while (rods_pending.size() != 0 || rod_ch.valid || damp_expected.size() != 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_e idx, longint value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[30:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SURFACE_RADIUS) radius_q = value & 64'h7FFF_FFFF;
        else damping_q = value & 64'h7FFF_FFFF;
    endtask

    initial
    begin
        longint radii [6];
        longint damps [6];
        rod_ch.valid = 1'b0;
        rod_ch.height_z = '0; rod_ch.dir_x = '0; rod_ch.dir_y = '0; rod_ch.dir_z = '0;
        rod_ch.rod_length = '0; rod_ch.vel_x = '0; rod_ch.vel_y = '0;
        rod_ch.spin_x = '0; rod_ch.spin_y = '0; rod_ch.spin_z = '0;
        damp_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rods at reset settings
        add_rod(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_rod(SMAX, 65536, 0, 0, 65536, 65536, 65536, 0, 0, 0);
        add_rod(SMIN, 0, 0, 65536, 32'h7FFF_FFFF, SMAX, SMIN, SMIN, SMAX, SMIN);
        add_rod(0, 65536, 0, 6, 4 * 65536, 65536, -65536, 65536, 65536, 65536);
        add_rod(0, 65536, 0, 7, 4 * 65536, 65536, -65536, 65536, 65536, 65536);
        add_rod(0, 0, 46341, -46341, 4 * 65536, -65536, 2 * 65536, 0, 65536, -65536);
        add_rod(32768, 0, 0, 65536, 2 * 65536, 65536, 65536, 65536, 0, 0);
        add_rod(32768, 0, 0, -65536, 8 * 65536, 65536, 65536, 0, 65536, 0);
        add_rod(-131072, -131072, 131071, -131072, 65536, 65536, 0, 0, 0, 65536);
        add_rod(-131072, 131071, -131072, 131071, 65536, 0, 65536, 65536, 65536, 65536);
        add_rod(65536, 65536, 0, 0, 2 * 65536, 65536, 0, 0, 0, 65536);
        add_rod(65535, 0, 65536, 0, 10 * 65536, SMAX, SMAX, SMAX, SMAX, SMAX);
        add_rod(-65536, 30000, 30000, 50000, 32'h7FFF_FFFF, 0, 0, SMAX, SMIN, SMAX);
        add_rod(0, -65536, -65536, -65536, 1, -1, -1, -1, -1, -1);
        add_rod(0, 0, 0, 65536, 3, 1, 1, 1, 1, 1);
        add_rod(SMIN, -65536, 65536, -6, 65536, SMIN, SMIN, SMIN, SMIN, SMIN);
        for (int i = 0; i < 60; i++) add_random_rod();
        settle();

        radii = '{65536, 32'h7FFF_FFFF, 1, 5 * 65536, 0, 3 * 65536};
        damps = '{65536, 0, 32'h7FFF_FFFF, 32768, 0, 2 * 65536};
        radii[4] = longint'($urandom_range(1, 16 * 65536));
        damps[4] = longint'($urandom_range(0, 8 * 65536));
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_SURFACE_RADIUS, radii[ph]);
            write_reg(REG_DAMPING_COEFF, damps[ph]);
            calm = (ph == 5);
            for (int i = 0; i < 75; i++) add_random_rod();
            settle();
        end

        if (errors == 0 && damp_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
